FILE: hdl/pnoise_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnoise_pkg
// Shared types, constants and a helper function for the 2D gradient noise unit.
// ----------------------------------------------------------------------------
package pnoise_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TBL_AW     = 8;
    localparam int TABLE_SIZE = 1 << TBL_AW;
    localparam int OUT_W      = 20;
    localparam int LAC_FRAC   = 12;
    localparam int PERS_FRAC  = 16;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // noise modes
    localparam logic [1:0] MODE_SINGLE  = 2'd0;
    localparam logic [1:0] MODE_FBM     = 2'd1;
    localparam logic [1:0] MODE_RIDGED  = 2'd2;
    localparam logic [1:0] MODE_BILLOWY = 2'd3;

    // register indexes
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_OCTAVES = 2'd1;
    localparam logic [1:0] REG_PERSIST = 2'd2;
    localparam logic [1:0] REG_LACUN   = 2'd3;

    // register reset values
    localparam logic [1:0]  RST_MODE    = MODE_FBM;
    localparam logic [3:0]  RST_OCTAVES = 4'd4;
    localparam logic [15:0] RST_PERSIST = 16'd32768;
    localparam logic [15:0] RST_LACUN   = 16'd8192;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sd524287;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -20'sd524288;

    typedef struct packed {
        logic              rd;
        logic [TBL_AW-1:0] raddr;
        logic              wr;
        logic [TBL_AW-1:0] waddr;
        logic [TBL_AW-1:0] wdata;
    } perm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // gradient dot product: +-a +-2b, a/b swapped for hash bit 2
    function automatic logic signed [19:0] corner_dot(
        input logic [TBL_AW-1:0]  h,
        input logic signed [17:0] dx,
        input logic signed [17:0] dy
    );
        logic signed [19:0] a;
        logic signed [19:0] b;
        logic signed [19:0] r;
        a = h[2] ? 20'(dy) : 20'(dx);
        b = h[2] ? 20'(dx) : 20'(dy);
        r = h[0] ? -a : a;
        r = h[1] ? (r - (b <<< 1)) : (r + (b <<< 1));
        return r;
    endfunction

endpackage

FILE: hdl/pnoise_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnoise_if
// Valid/ready stream interfaces for sample requests and noise results.
// ----------------------------------------------------------------------------
interface pnoise_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [7:0]         table_index;
    logic [7:0]         table_value;

    modport source (output valid, op, x_coord, y_coord, table_index, table_value,
                    input ready);
    modport sink   (input valid, op, x_coord, y_coord, table_index, table_value,
                    output ready);
endinterface

interface pnoise_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

FILE: hdl/perlin_noise_2d_octaves_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_2d_octaves_unit
// 2D gradient noise, single-octave or with fbm / ridged / billowy octave sums over a
// host-loaded permutation table.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  sample_in  in   valid/ready      op, x_coord, y_coord, table_index, table_value
//  noise_out  out  valid/ready      noise_value
//  apb        in   psel/penable     noise_mode, octave_count, persistence, lacunarity
//
//  a table write is done as it is accepted; a noise point makes six
//  reads per octave through the single permutation read port, then
//  a final normalizing divide
//  reset makes every table entry read as its own index, no clearing pass
//  one point is in work at a time; a finished result waits in the output
//  register while the next transaction is taken
// ----------------------------------------------------------------------------
module perlin_noise_2d_octaves_unit #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pnoise_pkg::APB_AW-1:0]   paddr,
    input  logic [pnoise_pkg::APB_DW-1:0]   pwdata,
    output logic [pnoise_pkg::APB_DW-1:0]   prdata,
    output logic                            pready,
    pnoise_in_if.sink                       sample_in,
    pnoise_out_if.source                    noise_out
);

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int WS_W  = 17 + $clog2(MAX_OCTAVES);
    localparam int DVD_W = WS_W + pnoise_pkg::OUT_W;
    localparam int TOT_W = 50 + $clog2(MAX_OCTAVES);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MUL  = 5'd1;
    localparam logic [4:0] S_ADD  = 5'd2;
    localparam logic [4:0] S_RA   = 5'd3;
    localparam logic [4:0] S_RD0  = 5'd4;
    localparam logic [4:0] S_RD1  = 5'd5;
    localparam logic [4:0] S_RD2  = 5'd6;
    localparam logic [4:0] S_RD3  = 5'd7;
    localparam logic [4:0] S_RD4  = 5'd8;
    localparam logic [4:0] S_RD5  = 5'd9;
    localparam logic [4:0] S_GRAD = 5'd10;
    localparam logic [4:0] S_L1   = 5'd11;
    localparam logic [4:0] S_L2   = 5'd12;
    localparam logic [4:0] S_TERM = 5'd13;
    localparam logic [4:0] S_PROD = 5'd14;
    localparam logic [4:0] S_ACC  = 5'd15;
    localparam logic [4:0] S_DIVS = 5'd16;
    localparam logic [4:0] S_DIVW = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    // configuration registers
    logic [1:0]  noise_mode_reg;
    logic [3:0]  octave_count_reg;
    logic [15:0] persistence_reg;
    logic [15:0] lacunarity_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_mode_reg   <= pnoise_pkg::RST_MODE;
            octave_count_reg <= pnoise_pkg::RST_OCTAVES;
            persistence_reg  <= pnoise_pkg::RST_PERSIST;
            lacunarity_reg   <= pnoise_pkg::RST_LACUN;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                pnoise_pkg::REG_MODE:    noise_mode_reg   <= pwdata[1:0];
                pnoise_pkg::REG_OCTAVES: octave_count_reg <= pwdata[3:0];
                pnoise_pkg::REG_PERSIST: persistence_reg  <= pwdata[15:0];
                pnoise_pkg::REG_LACUN:   lacunarity_reg   <= pwdata[15:0];
                default:                 noise_mode_reg   <= noise_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pnoise_pkg::REG_MODE:    prdata = 32'(noise_mode_reg);
            pnoise_pkg::REG_OCTAVES: prdata = 32'(octave_count_reg);
            pnoise_pkg::REG_PERSIST: prdata = 32'(persistence_reg);
            pnoise_pkg::REG_LACUN:   prdata = 32'(lacunarity_reg);
            default:                 prdata = '0;
        endcase
    end

    // sequencer state and datapath registers
    logic [4:0]               state_reg;
    logic [4:0]               state_next;
    logic signed [31:0]       x_reg;
    logic signed [31:0]       y_reg;
    logic [1:0]               mode_reg;
    logic [OCT_W-1:0]         n_oct_reg;
    logic [OCT_W-1:0]         oct_reg;
    logic [31:0]              freq_reg;
    logic [16:0]              amp_reg;
    logic [WS_W-1:0]          wsum_reg;
    logic signed [TOT_W-1:0]  total_reg;
    logic [35:0]              plox_reg;
    logic [35:0]              ploy_reg;
    logic [19:0]              phix_reg;
    logic [19:0]              phiy_reg;
    logic [7:0]               cx_reg;
    logic [7:0]               cy_reg;
    logic [15:0]              fx_reg;
    logic [15:0]              fy_reg;
    logic [15:0]              t2x_reg;
    logic [15:0]              t2y_reg;
    logic [15:0]              t3x_reg;
    logic [15:0]              t3y_reg;
    logic [19:0]              qx_reg;
    logic [19:0]              qy_reg;
    logic [17:0]              ux_reg;
    logic [17:0]              uy_reg;
    logic [7:0]               pa_reg;
    logic [7:0]               pb_reg;
    logic [7:0]               haa_reg;
    logic [7:0]               hab_reg;
    logic [7:0]               hba_reg;
    logic [7:0]               hbb_reg;
    logic signed [19:0]       g1_reg;
    logic signed [19:0]       g2_reg;
    logic signed [19:0]       g3_reg;
    logic signed [19:0]       g4_reg;
    logic signed [23:0]       l1_reg;
    logic signed [23:0]       l2_reg;
    logic signed [23:0]       n_reg;
    logic signed [31:0]       term_reg;
    logic signed [49:0]       prod_reg;
    logic                     neg_reg;
    logic [pnoise_pkg::OUT_W-1:0] res_reg;
    logic                     out_valid_reg;
    logic [pnoise_pkg::OUT_W-1:0] out_data_reg;

    logic                     in_acc;
    logic                     last_oct;
    logic [OCT_W-1:0]         n_oct_cfg;

    // memory and divider connections
    pnoise_pkg::perm_req_t    preq;
    logic [7:0]               rdata;
    pnoise_pkg::div_stat_t    dstat;
    logic [pnoise_pkg::OUT_W-1:0] quot;
    logic                     div_start;
    logic [TOT_W-1:0]         mag;
    logic [TOT_W-1:0]         lim;

    // combinational arithmetic
    logic [35:0]        x36;
    logic [35:0]        y36;
    logic [51:0]        mlox;
    logic [51:0]        mloy;
    logic [35:0]        mhix;
    logic [35:0]        mhiy;
    logic [35:0]        sx;
    logic [35:0]        sy;
    logic [31:0]        sqx;
    logic [31:0]        sqy;
    logic [31:0]        cubx;
    logic [31:0]        cuby;
    logic [22:0]        qxw;
    logic [22:0]        qyw;
    logic [35:0]        pux;
    logic [35:0]        puy;
    logic signed [17:0] dx0;
    logic signed [17:0] dx1;
    logic signed [17:0] dy0;
    logic signed [17:0] dy1;
    logic signed [20:0] d21;
    logic signed [20:0] d43;
    logic signed [39:0] bl1;
    logic signed [39:0] bl2;
    logic signed [24:0] dl;
    logic signed [43:0] bn;
    logic signed [23:0] absn;
    logic signed [24:0] ridge_m;
    logic signed [49:0] ridge_sq;
    logic signed [31:0] term_sel;
    logic [47:0]        flac;
    logic [35:0]        fsc;
    logic [32:0]        apers;

    assign in_acc   = sample_in.valid & sample_in.ready;
    assign last_oct = ((oct_reg + 1'b1) == n_oct_reg);

    always_comb
    begin
        if (octave_count_reg == 4'd0)
        begin
            n_oct_cfg = OCT_W'(1);
        end
        else if (32'(octave_count_reg) > MAX_OCTAVES)
        begin
            n_oct_cfg = OCT_W'(MAX_OCTAVES);
        end
        else
        begin
            n_oct_cfg = OCT_W'(octave_count_reg);
        end
    end

    // scaled coordinate, only bits 35:12 of coord * freq are needed
    assign x36  = 36'(x_reg);
    assign y36  = 36'(y_reg);
    assign mlox = x36 * freq_reg[15:0];
    assign mloy = y36 * freq_reg[15:0];
    assign mhix = x_reg[19:0] * freq_reg[31:16];
    assign mhiy = y_reg[19:0] * freq_reg[31:16];
    assign sx   = plox_reg + {phix_reg, 16'b0};
    assign sy   = ploy_reg + {phiy_reg, 16'b0};

    // quintic fade
    assign sqx  = fx_reg * fx_reg;
    assign sqy  = fy_reg * fy_reg;
    assign cubx = t2x_reg * fx_reg;
    assign cuby = t2y_reg * fy_reg;
    assign qxw  = 23'(t2x_reg) * 23'd6 + 23'd655360 - 23'(fx_reg) * 23'd15;
    assign qyw  = 23'(t2y_reg) * 23'd6 + 23'd655360 - 23'(fy_reg) * 23'd15;
    assign pux  = t3x_reg * qx_reg;
    assign puy  = t3y_reg * qy_reg;

    // corner offsets
    assign dx0 = $signed({2'b00, fx_reg});
    assign dy0 = $signed({2'b00, fy_reg});
    assign dx1 = dx0 - 18'sd65536;
    assign dy1 = dy0 - 18'sd65536;

    // blends, products floored by arithmetic shift
    assign d21 = 21'(g2_reg) - 21'(g1_reg);
    assign d43 = 21'(g4_reg) - 21'(g3_reg);
    assign bl1 = $signed({1'b0, ux_reg}) * d21;
    assign bl2 = $signed({1'b0, ux_reg}) * d43;
    assign dl  = 25'(l2_reg) - 25'(l1_reg);
    assign bn  = $signed({1'b0, uy_reg}) * dl;

    // per-octave term
    assign absn     = n_reg[23] ? -n_reg : n_reg;
    assign ridge_m  = 25'sd65536 - 25'(absn);
    assign ridge_sq = ridge_m * ridge_m;

    always_comb
    begin
        unique case (mode_reg)
            pnoise_pkg::MODE_RIDGED:  term_sel = 32'(ridge_sq >>> 16);
            pnoise_pkg::MODE_BILLOWY: term_sel = 32'(absn);
            default:                  term_sel = 32'(n_reg);
        endcase
    end

    assign flac  = freq_reg * lacunarity_reg;
    assign fsc   = flac[47:12];
    assign apers = amp_reg * persistence_reg;

    assign mag = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
    assign lim = TOT_W'({wsum_reg, 20'b0});

    // permutation memory requests
    always_comb
    begin
        preq.rd    = 1'b0;
        preq.raddr = cx_reg;
        preq.wr    = in_acc & ~sample_in.op;
        preq.waddr = sample_in.table_index;
        preq.wdata = sample_in.table_value;
        unique case (state_reg)
            S_RA:
            begin
                preq.rd    = 1'b1;
                preq.raddr = cx_reg;
            end
            S_RD0:
            begin
                preq.rd    = 1'b1;
                preq.raddr = cx_reg + 8'd1;
            end
            S_RD1:
            begin
                preq.rd    = 1'b1;
                preq.raddr = pa_reg + cy_reg;
            end
            S_RD2:
            begin
                preq.rd    = 1'b1;
                preq.raddr = pa_reg + cy_reg + 8'd1;
            end
            S_RD3:
            begin
                preq.rd    = 1'b1;
                preq.raddr = pb_reg + cy_reg;
            end
            S_RD4:
            begin
                preq.rd    = 1'b1;
                preq.raddr = pb_reg + cy_reg + 8'd1;
            end
            default:
            begin
                preq.rd = 1'b0;
            end
        endcase
    end

    pnoise_perm_ram u_perm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (preq),
        .rdata (rdata)
    );

    assign div_start = (state_reg == S_DIVS) && (mag < lim);

    pnoise_divider #(
        .WS_W (WS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag[DVD_W-1:0]),
        .divisor  (wsum_reg),
        .stat     (dstat),
        .quotient (quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc && sample_in.op) state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:  state_next = S_RA;
            S_RA:   state_next = S_RD0;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_RD3;
            S_RD3:  state_next = S_RD4;
            S_RD4:  state_next = S_RD5;
            S_RD5:  state_next = S_GRAD;
            S_GRAD: state_next = S_L1;
            S_L1:   state_next = S_L2;
            S_L2:   state_next = S_TERM;
            S_TERM: state_next = S_PROD;
            S_PROD: state_next = S_ACC;
            S_ACC:  state_next = last_oct ? S_DIVS : S_MUL;
            S_DIVS: state_next = (mag < lim) ? S_DIVW : S_OUT;
            S_DIVW: if (dstat.done) state_next = S_OUT;
            S_OUT:  if (!out_valid_reg || noise_out.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!out_valid_reg || noise_out.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (noise_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    x_reg     <= sample_in.x_coord;
                    y_reg     <= sample_in.y_coord;
                    mode_reg  <= noise_mode_reg;
                    n_oct_reg <= (noise_mode_reg == pnoise_pkg::MODE_SINGLE) ?
                                 OCT_W'(1) : n_oct_cfg;
                    oct_reg   <= '0;
                    freq_reg  <= 32'd1 << pnoise_pkg::LAC_FRAC;
                    amp_reg   <= 17'd1 << pnoise_pkg::PERS_FRAC;
                    wsum_reg  <= '0;
                    total_reg <= '0;
                end
            end
            S_MUL:
            begin
                plox_reg <= mlox[35:0];
                ploy_reg <= mloy[35:0];
                phix_reg <= mhix[19:0];
                phiy_reg <= mhiy[19:0];
            end
            S_ADD:
            begin
                cx_reg <= sx[35:28];
                cy_reg <= sy[35:28];
                fx_reg <= sx[27:12];
                fy_reg <= sy[27:12];
            end
            S_RA:
            begin
                t2x_reg <= sqx[31:16];
                t2y_reg <= sqy[31:16];
            end
            S_RD0:
            begin
                pa_reg  <= rdata;
                t3x_reg <= cubx[31:16];
                t3y_reg <= cuby[31:16];
                qx_reg  <= qxw[19:0];
                qy_reg  <= qyw[19:0];
            end
            S_RD1:
            begin
                pb_reg <= rdata;
                ux_reg <= pux[33:16];
                uy_reg <= puy[33:16];
            end
            S_RD2: haa_reg <= rdata;
            S_RD3: hab_reg <= rdata;
            S_RD4: hba_reg <= rdata;
            S_RD5: hbb_reg <= rdata;
            S_GRAD:
            begin
                g1_reg <= pnoise_pkg::corner_dot(haa_reg, dx0, dy0);
                g2_reg <= pnoise_pkg::corner_dot(hba_reg, dx1, dy0);
                g3_reg <= pnoise_pkg::corner_dot(hab_reg, dx0, dy1);
                g4_reg <= pnoise_pkg::corner_dot(hbb_reg, dx1, dy1);
            end
            S_L1:
            begin
                l1_reg <= 24'(g1_reg) + 24'(bl1 >>> 16);
                l2_reg <= 24'(g3_reg) + 24'(bl2 >>> 16);
            end
            S_L2: n_reg <= l1_reg + 24'(bn >>> 16);
            S_TERM: term_reg <= term_sel;
            S_PROD:
            begin
                prod_reg <= term_reg * $signed({1'b0, amp_reg});
                wsum_reg <= wsum_reg + WS_W'(amp_reg);
                amp_reg  <= apers[32:16];
                freq_reg <= (|fsc[35:32]) ? 32'hFFFF_FFFF : fsc[31:0];
            end
            S_ACC:
            begin
                total_reg <= total_reg + TOT_W'(prod_reg);
                oct_reg   <= oct_reg + 1'b1;
            end
            S_DIVS:
            begin
                neg_reg <= total_reg[TOT_W-1];
                if (mag >= lim)
                begin
                    res_reg <= total_reg[TOT_W-1] ? pnoise_pkg::OUT_MIN : pnoise_pkg::OUT_MAX;
                end
            end
            S_DIVW:
            begin
                if (dstat.done)
                begin
                    if (neg_reg)
                    begin
                        res_reg <= quot[19] ? pnoise_pkg::OUT_MIN : -quot;
                    end
                    else
                    begin
                        res_reg <= quot[19] ? pnoise_pkg::OUT_MAX : quot;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || noise_out.ready)
                begin
                    out_data_reg <= res_reg;
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign sample_in.ready       = (state_reg == S_IDLE);
    assign noise_out.valid       = out_valid_reg;
    assign noise_out.noise_value = out_data_reg;

endmodule

FILE: hdl/pnoise_perm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnoise_perm_ram
// Permutation table memory, one read and one write port, registered read.
// Entries never written read back as their own index.
// ----------------------------------------------------------------------------
module pnoise_perm_ram (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pnoise_pkg::perm_req_t             req,
    output logic [pnoise_pkg::TBL_AW-1:0]     rdata
);

    logic [pnoise_pkg::TBL_AW-1:0]     perm_mem [pnoise_pkg::TABLE_SIZE];
    logic [pnoise_pkg::TABLE_SIZE-1:0] valid_reg;
    logic [pnoise_pkg::TBL_AW-1:0]     mem_q_reg;
    logic [pnoise_pkg::TBL_AW-1:0]     raddr_reg;
    logic                              hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            perm_mem[req.waddr] <= req.wdata;
        end
        if (req.rd)
        begin
            mem_q_reg <= perm_mem[req.raddr];
            raddr_reg <= req.raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.rd)
            begin
                hit_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign rdata = hit_reg ? mem_q_reg : raddr_reg;

endmodule

FILE: hdl/pnoise_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnoise_divider
// Restoring divider, one quotient bit per cycle, 20-bit quotient.
// The dividend must be below divisor * 2^20.
// ----------------------------------------------------------------------------
module pnoise_divider #(
    parameter int WS_W = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [WS_W+pnoise_pkg::OUT_W-1:0]    dividend,
    input  logic [WS_W-1:0]                      divisor,
    output pnoise_pkg::div_stat_t                stat,
    output logic [pnoise_pkg::OUT_W-1:0]         quotient
);

    localparam int DVD_W = WS_W + pnoise_pkg::OUT_W;
    localparam int CNT_W = $clog2(pnoise_pkg::OUT_W);

    logic [DVD_W-1:0]             rem_reg;
    logic [DVD_W-1:0]             sh_reg;
    logic [pnoise_pkg::OUT_W-1:0] q_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic                         fit;

    assign fit = (rem_reg >= sh_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            sh_reg  <= DVD_W'({divisor, {(pnoise_pkg::OUT_W-1){1'b0}}});
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fit ? (rem_reg - sh_reg) : rem_reg;
            sh_reg  <= sh_reg >> 1;
            q_reg   <= {q_reg[pnoise_pkg::OUT_W-2:0], fit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(pnoise_pkg::OUT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2D gradient noise unit: loads permutation
// entries, evaluates points under every noise mode and a range of octave settings, and
// compares each noise result against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pnoise_pkg::APB_AW-1:0] paddr = '0;
    logic [pnoise_pkg::APB_DW-1:0] pwdata = '0;
    logic [pnoise_pkg::APB_DW-1:0] prdata;
    logic pready;

    pnoise_in_if sample_in ();
    pnoise_out_if noise_out ();

    perlin_noise_2d_octaves_unit dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample_in(sample_in.sink), .noise_out(noise_out.source)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [7:0]  perm_model [pnoise_pkg::TABLE_SIZE];
    logic [1:0]  mode_model;
    logic [3:0]  octaves_model;
    logic [15:0] persist_model;
    logic [15:0] lacun_model;

    logic signed [19:0] noise_expected [$];
    int error_count = 0;
    int cycle_count = 0;
    int gap_max = 4;
    int send_burst = 0;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    function automatic longint fade_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0)
            return p >>> pnoise_pkg::FRAC_BITS;
        return -((-p + (64'sd1 << pnoise_pkg::FRAC_BITS) - 1) >>> pnoise_pkg::FRAC_BITS);
    endfunction

    function automatic longint quintic(input longint t);
        longint t2;
        longint t3;
        t2 = (t * t) >>> pnoise_pkg::FRAC_BITS;
        t3 = (t2 * t) >>> pnoise_pkg::FRAC_BITS;
        return fade_mul(t3, 6 * t2 - 15 * t + 10 * (64'sd1 << pnoise_pkg::FRAC_BITS));
    endfunction

    function automatic longint grad(input logic [7:0] h, input longint dx, input longint dy);
        longint a;
        longint b;
        longint r;
        a = h[2] ? dy : dx;
        b = h[2] ? dx : dy;
        r = h[0] ? -a : a;
        r += h[1] ? -2 * b : 2 * b;
        return r;
    endfunction

    function automatic longint lattice_sample(input logic [63:0] sx, input logic [63:0] sy);
        logic [7:0] cx;
        logic [7:0] cy;
        logic [7:0] pa;
        logic [7:0] pb;
        longint fx;
        longint fy;
        longint u;
        longint v;
        longint g1, g2, g3, g4, l1, l2;
        longint one;
        one = 64'sd1 << pnoise_pkg::FRAC_BITS;
        cx = sx[pnoise_pkg::FRAC_BITS +: 8];
        cy = sy[pnoise_pkg::FRAC_BITS +: 8];
        fx = longint'(sx[pnoise_pkg::FRAC_BITS-1:0]);
        fy = longint'(sy[pnoise_pkg::FRAC_BITS-1:0]);
        pa = perm_model[cx];
        pb = perm_model[8'(cx + 8'd1)];
        u = quintic(fx);
        v = quintic(fy);
        g1 = grad(perm_model[8'(pa + cy)], fx, fy);
        g2 = grad(perm_model[8'(pb + cy)], fx - one, fy);
        g3 = grad(perm_model[8'(pa + cy + 8'd1)], fx, fy - one);
        g4 = grad(perm_model[8'(pb + cy + 8'd1)], fx - one, fy - one);
        l1 = g1 + fade_mul(u, g2 - g1);
        l2 = g3 + fade_mul(u, g4 - g3);
        return l1 + fade_mul(v, l2 - l1);
    endfunction

    function automatic logic signed [19:0] predict_noise(input logic signed [31:0] x,
                                                         input logic signed [31:0] y);
        logic [63:0] xs;
        logic [63:0] ys;
        logic [63:0] freq;
        logic [63:0] amp;
        longint res;
        longint total;
        longint wsum;
        longint n;
        longint m;
        longint term;
        int n_oct;
        xs = 64'(x);
        ys = 64'(y);
        if (mode_model == pnoise_pkg::MODE_SINGLE)
            res = lattice_sample(xs, ys);
        else
        begin
            n_oct = (octaves_model < 1) ? 1 : (octaves_model > 8 ? 8 : int'(octaves_model));
            freq = 64'd1 << pnoise_pkg::LAC_FRAC;
            amp = 64'd1 << pnoise_pkg::PERS_FRAC;
            total = 0;
            wsum = 0;
            for (int i = 0; i < n_oct; i++)
            begin
                n = lattice_sample((xs * freq) >> pnoise_pkg::LAC_FRAC,
                                   (ys * freq) >> pnoise_pkg::LAC_FRAC);
                if (mode_model == pnoise_pkg::MODE_RIDGED)
                begin
                    m = (64'sd1 << pnoise_pkg::FRAC_BITS) - (n < 0 ? -n : n);
                    term = (m * m) >>> pnoise_pkg::FRAC_BITS;
                end
                else if (mode_model == pnoise_pkg::MODE_BILLOWY)
                    term = n < 0 ? -n : n;
                else
                    term = n;
                total += term * longint'(amp);
                wsum += longint'(amp);
                amp = (amp * persist_model) >> pnoise_pkg::PERS_FRAC;
                freq = (freq * lacun_model) >> pnoise_pkg::LAC_FRAC;
                if (freq > 64'hFFFF_FFFF)
                    freq = 64'hFFFF_FFFF;
            end
            res = total / wsum;
        end
        if (res > 524287)
            res = 524287;
        if (res < -524288)
            res = -524288;
        return 20'(res);
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= pnoise_pkg::APB_AW'(4 * idx);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pnoise_pkg::REG_MODE:    mode_model = value[1:0];
            pnoise_pkg::REG_OCTAVES: octaves_model = value[3:0];
            pnoise_pkg::REG_PERSIST: persist_model = value[15:0];
            default:                 lacun_model = value[15:0];
        endcase
    endtask

    // sends one transaction; bursts with random gaps
    task automatic send_item(input logic op, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic [7:0] idx,
                             input logic [7:0] val);
        int gap;
        if (send_burst == 0)
        begin
            gap = $urandom_range(gap_max, 0);
            if (gap > 0)
            begin
                sample_in.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            send_burst = $urandom_range(8, 1);
        end
        send_burst--;
        sample_in.valid <= 1'b1;
        sample_in.op <= op;
        sample_in.x_coord <= x;
        sample_in.y_coord <= y;
        sample_in.table_index <= idx;
        sample_in.table_value <= val;
        do @(posedge clk); while (!sample_in.ready);
        if (op)
            noise_expected.push_back(predict_noise(x, y));
        else
            perm_model[idx] = val;
        @(negedge clk);
    endtask

    task automatic drain();
        sample_in.valid <= 1'b0;
        send_burst = 0;
        while (noise_expected.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3, 0))
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 20, 0)) - (1 << 19));
            2: return {$urandom_range(1, 0) ? 8'hFF : 8'h00, 24'($urandom)};
            default: return {16'($urandom_range(300, 0)), 16'($urandom)};
        endcase
    endfunction

    task automatic test_extremes();
        logic [31:0] pts [6];
        pts = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0001_0000};
        reg_write(pnoise_pkg::REG_MODE, pnoise_pkg::MODE_SINGLE);
        foreach (pts[i])
            send_item(1'b1, pts[i], pts[5 - i], 8'h00, 8'h00);
        send_item(1'b1, 32'h0000_8000, 32'h00FF_8000, 8'h00, 8'h00);
    endtask

    task automatic test_table_load();
        send_item(1'b0, 32'h0, 32'h0, 8'hFF, 8'h00);
        send_item(1'b0, 32'h0, 32'h0, 8'h00, 8'hFF);
        send_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hAA, 8'h55);
        for (int i = 0; i < 8; i++)
            send_item(1'b0, 32'h0, 32'h0, 8'(i), 8'($urandom));
        send_item(1'b1, 32'h0000_4000, 32'h0001_C000, 8'h00, 8'h00);
        send_item(1'b1, 32'h00FF_C000, 32'h00FF_4000, 8'h00, 8'h00);
    endtask

    task automatic test_mode_sweep();
        logic [1:0] modes [4];
        modes = '{pnoise_pkg::MODE_SINGLE, pnoise_pkg::MODE_FBM,
                  pnoise_pkg::MODE_RIDGED, pnoise_pkg::MODE_BILLOWY};
        foreach (modes[m])
        begin
            drain();
            reg_write(pnoise_pkg::REG_MODE, modes[m]);
            reg_write(pnoise_pkg::REG_OCTAVES, 32'(m == 1 ? 0 : (m == 2 ? 15 : 8)));
            reg_write(pnoise_pkg::REG_PERSIST, m == 3 ? 32'hFFFF : 32'h0);
            reg_write(pnoise_pkg::REG_LACUN, m == 2 ? 32'h0 : 32'hFFFF);
            send_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00, 8'h00);
            send_item(1'b1, rand_coord(), rand_coord(), 8'h00, 8'h00);
        end
    endtask

    task automatic test_random(input int count);
        for (int p = 0; p < 8; p++)
        begin
            drain();
            gap_max = (p % 3 == 0) ? 0 : 6;
            reg_write(pnoise_pkg::REG_MODE, 32'($urandom_range(3, 0)));
            reg_write(pnoise_pkg::REG_OCTAVES,
                      p < 6 ? 32'($urandom_range(3, 0)) : 32'($urandom_range(15, 0)));
            reg_write(pnoise_pkg::REG_PERSIST, $urandom);
            reg_write(pnoise_pkg::REG_LACUN,
                      $urandom_range(3, 0) == 0 ? $urandom : 32'($urandom_range(12288, 2048)));
            for (int i = 0; i < count / 8; i++)
            begin
                if ($urandom_range(4, 0) == 0)
                    send_item(1'b0, $urandom, $urandom, 8'($urandom), 8'($urandom));
                else
                    send_item(1'b1, rand_coord(), rand_coord(), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // checks each accepted noise result
    always @(posedge clk)
    begin
        if (rst_n && noise_out.valid && noise_out.ready)
        begin
            if (noise_expected.size() == 0)
                report("noise result with nothing expected");
            else if (noise_out.noise_value !== noise_expected[0])
            begin
                report($sformatf("noise_value got %0d want %0d",
                                 noise_out.noise_value, noise_expected[0]));
                void'(noise_expected.pop_front());
            end
            else
                void'(noise_expected.pop_front());
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (cycle_count % 2000 < 400)
            noise_out.ready <= 1'b1;
        else
            noise_out.ready <= ($urandom_range(3, 0) != 0);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        sample_in.valid = 1'b0;
        sample_in.op = 1'b0;
        sample_in.x_coord = '0;
        sample_in.y_coord = '0;
        sample_in.table_index = '0;
        sample_in.table_value = '0;
        noise_out.ready = 1'b0;
        for (int i = 0; i < pnoise_pkg::TABLE_SIZE; i++)
            perm_model[i] = 8'(i);
        mode_model = pnoise_pkg::RST_MODE;
        octaves_model = pnoise_pkg::RST_OCTAVES;
        persist_model = pnoise_pkg::RST_PERSIST;
        lacun_model = pnoise_pkg::RST_LACUN;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // reset register values first
        send_item(1'b1, 32'h0003_2000, 32'hFFFE_1000, 8'h00, 8'h00);
        drain();
        test_extremes();
        test_table_load();
        test_mode_sweep();
        test_random(1000);
        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: files.f
hdl/pnoise_pkg.sv
hdl/pnoise_if.sv
hdl/pnoise_perm_ram.sv
hdl/pnoise_divider.sv
hdl/perlin_noise_2d_octaves_unit.sv
test/tb.sv
